// ===== sv/chtb_pkg.sv =====
// Package for the canonical Huffman table builder.
// Holds field widths, codes, controller state type and the command/status structs.
// No dependencies.
package chtb_pkg;

    // Table geometry
    localparam int MAX_CODE_LENGTH = 16;
    localparam int SYMBOL_COUNT    = 256;
    localparam int SYM_W           = 8;
    localparam int LEN_W           = 5;
    localparam int CODE_W          = 16;
    localparam int NEXT_W          = CODE_W + 1;
    localparam int CNT_W           = 8;
    localparam int IDX_W           = $clog2(MAX_CODE_LENGTH);
    localparam int BI_W            = 5;

    // Saturation value of the running code
    localparam logic [NEXT_W-1:0] CODE_SAT = '1;

    // Byte index positions after the count bytes
    localparam logic [BI_W-1:0] BI_SYMBOLS = BI_W'(MAX_CODE_LENGTH);
    localparam logic [BI_W-1:0] BI_DONE    = BI_W'(MAX_CODE_LENGTH + 1);

    // Request and answer codes
    localparam logic REQ_SPEC     = 1'b0;
    localparam logic REQ_LOOKUP   = 1'b1;
    localparam logic KIND_ASSIGN  = 1'b0;
    localparam logic KIND_LOOKUP  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_WORK
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input transaction taken this cycle
        logic work;      // controller is in the work state
        logic load_out;  // move the pending result into the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic lookup;       // incoming item is a lookup
        logic starts_work;  // incoming spec byte needs the length walk
        logic has_result;   // incoming spec byte is an assigned symbol
        logic settled;      // length walk has nothing left to do
    } t_stat;

    typedef struct packed {
        logic              answer_kind;
        logic [SYM_W-1:0]  symbol_value;
        logic [LEN_W-1:0]  code_size;
        logic [CODE_W-1:0] code_bits;
        logic              found;
        logic              code_overflow;
        logic              spec_done;
    } t_result;

endpackage

// ===== sv/chtb_if.sv =====
// Valid/ready channel interfaces for the canonical Huffman table builder.
// Depends on chtb_pkg.
interface chtb_in_if import chtb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic             first_byte;
    logic [SYM_W-1:0] data_byte;

    modport source (output valid, output req_type, output first_byte, output data_byte,
                    input ready);
    modport sink   (input valid, input req_type, input first_byte, input data_byte,
                    output ready);
endinterface

interface chtb_out_if import chtb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              answer_kind;
    logic [SYM_W-1:0]  symbol_value;
    logic [LEN_W-1:0]  code_size;
    logic [CODE_W-1:0] code_bits;
    logic              found;
    logic              code_overflow;
    logic              spec_done;

    modport source (output valid, output answer_kind, output symbol_value,
                    output code_size, output code_bits, output found,
                    output code_overflow, output spec_done, input ready);
    modport sink   (input valid, input answer_kind, input symbol_value,
                    input code_size, input code_bits, input found,
                    input code_overflow, input spec_done, output ready);
endinterface

// ===== sv/chtb_dp.sv =====
// Datapath: count registers, length walk, symbol table and result registers.
// Depends on chtb_pkg; driven by chtb_ctrl through t_cmd.
module chtb_dp import chtb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_type,
    input  logic             i_first_byte,
    input  logic [SYM_W-1:0] i_data_byte,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output t_result          o_result
);

    // Spec walk state
    logic [BI_W-1:0]   r_bi;
    logic [CNT_W-1:0]  r_counts [MAX_CODE_LENGTH];
    logic [LEN_W-1:0]  r_cur_len;
    logic [CNT_W-1:0]  r_left;
    logic [NEXT_W-1:0] r_next_code;

    // Symbol table: presence in flops, entries in memory
    logic [SYMBOL_COUNT-1:0]   r_present;
    logic [LEN_W+CODE_W-1:0]   r_mem [SYMBOL_COUNT];
    logic [LEN_W+CODE_W-1:0]   r_rd;

    // Pending result and output register
    t_result r_res;
    t_result r_out;
    t_result n_out;

    logic [BI_W-1:0]   w_bi_eff;
    logic              w_spec;
    logic              w_is_count;
    logic              w_is_last;
    logic              w_is_symbol;
    logic              w_in_table;
    logic              w_fresh;
    logic              w_ovf;
    logic              w_settled;
    logic [NEXT_W-1:0] w_code_inc;
    logic [NEXT_W-1:0] w_code_dbl;
    logic [CNT_W-1:0]  w_first_count;

    // Decode of the incoming item against the spec position
    always_comb begin
        w_spec      = (i_req_type == REQ_SPEC);
        w_bi_eff    = i_first_byte ? '0 : r_bi;
        w_is_count  = (w_bi_eff < BI_SYMBOLS);
        w_is_last   = (w_bi_eff == BI_SYMBOLS - BI_W'(1));
        w_is_symbol = (w_bi_eff == BI_SYMBOLS);
        w_in_table  = ({1'b0, i_data_byte} < (SYM_W + 1)'(SYMBOL_COUNT));
        w_fresh     = w_in_table && !r_present[i_data_byte];
        w_ovf       = ((r_next_code >> r_cur_len) != '0);
        w_settled   = !((r_bi == BI_SYMBOLS) && (r_left == '0));
        w_code_inc  = (r_next_code != CODE_SAT) ? r_next_code + NEXT_W'(1) : r_next_code;
        w_code_dbl  = r_next_code[NEXT_W-1] ? CODE_SAT : {r_next_code[NEXT_W-2:0], 1'b0};
        // count of length one may be the byte arriving now
        w_first_count = (w_bi_eff == '0) ? i_data_byte : r_counts[0];
    end

    always_comb begin
        o_stat.lookup      = !w_spec;
        o_stat.starts_work = w_spec && (w_is_last || w_is_symbol);
        o_stat.has_result  = w_spec && w_is_symbol;
        o_stat.settled     = w_settled;
    end

    // Count bytes
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_spec && w_is_count) begin
            r_counts[w_bi_eff[IDX_W-1:0]] <= i_data_byte;
        end
    end

    // Spec position, length walk and presence bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bi        <= '0;
            r_cur_len   <= LEN_W'(1);
            r_left      <= '0;
            r_next_code <= '0;
            r_present   <= '0;
        end else if (i_cmd.accept && w_spec) begin
            if (w_is_count) begin
                r_bi <= w_bi_eff + BI_W'(1);
                if (w_is_last) begin
                    r_cur_len   <= LEN_W'(1);
                    r_next_code <= '0;
                    r_left      <= w_first_count;
                end
            end else if (w_is_symbol) begin
                if (w_fresh) begin
                    r_present[i_data_byte] <= 1'b1;
                end
                r_next_code <= w_code_inc;
                r_left      <= r_left - CNT_W'(1);
            end
        end else if (i_cmd.work && !w_settled) begin
            // one length step per cycle
            if (r_cur_len >= LEN_W'(MAX_CODE_LENGTH)) begin
                r_bi <= BI_DONE;
            end else begin
                r_next_code <= w_code_dbl;
                r_cur_len   <= r_cur_len + LEN_W'(1);
                r_left      <= r_counts[r_cur_len[IDX_W-1:0]];
            end
        end
    end

    // Entry memory: write on a fresh assignment, registered read on a lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_spec && w_is_symbol && w_fresh) begin
            r_mem[i_data_byte] <= {r_cur_len, r_next_code[CODE_W-1:0]};
        end
        if (i_cmd.accept && !w_spec) begin
            r_rd <= r_mem[i_data_byte];
        end
    end

    // Pending result capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res.symbol_value <= i_data_byte;
            r_res.spec_done    <= 1'b0;
            if (!w_spec) begin
                r_res.answer_kind   <= KIND_LOOKUP;
                r_res.code_size     <= '0;
                r_res.code_bits     <= '0;
                r_res.found         <= w_in_table && r_present[i_data_byte];
                r_res.code_overflow <= 1'b0;
            end else begin
                r_res.answer_kind   <= KIND_ASSIGN;
                r_res.code_size     <= r_cur_len;
                r_res.code_bits     <= r_next_code[CODE_W-1:0];
                r_res.found         <= w_fresh;
                r_res.code_overflow <= w_ovf;
            end
        end
    end

    // Final result: table entry for a lookup hit, spec end for an assignment
    always_comb begin
        n_out = r_res;
        if (r_res.answer_kind == KIND_LOOKUP) begin
            if (r_res.found) begin
                n_out.code_size = r_rd[LEN_W+CODE_W-1:CODE_W];
                n_out.code_bits = r_rd[CODE_W-1:0];
            end
        end else begin
            n_out.spec_done = (r_bi == BI_DONE);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

endmodule

// ===== sv/chtb_ctrl.sv =====
// Controller: accepts items, runs the length walk, hands results to the output.
// Depends on chtb_pkg; talks to chtb_dp through t_cmd and t_stat.
module chtb_ctrl import chtb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_ready,
    output logic  o_out_valid,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_pending;
    logic   n_pending;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_slot_free;
    logic   w_load;

    // nothing is taken while reset is held
    assign w_accept    = i_in_valid && i_rst_n && (r_state == ST_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_pending = i_stat.lookup || i_stat.has_result;
                    if (i_stat.lookup || i_stat.starts_work) begin
                        n_state = ST_WORK;
                    end
                end
            end
            ST_WORK: begin
                if (i_stat.settled && (!r_pending || w_slot_free)) begin
                    n_state   = ST_IDLE;
                    n_pending = 1'b0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = i_rst_n && (r_state == ST_IDLE);
        w_load         = (r_state == ST_WORK) && i_stat.settled && r_pending && w_slot_free;
        o_cmd.accept   = w_accept;
        o_cmd.work     = (r_state == ST_WORK);
        o_cmd.load_out = w_load;
        n_out_valid    = w_load ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/canonical_huffman_table_builder.sv =====
// Canonical Huffman table builder: a spec byte stream in, code assignments and
// lookup answers out. A count byte other than the last is taken without entering
// the work state. The last count byte and a symbol byte each enter it and run the
// length walk that follows there: one step for every code length moved past once
// its codes are used up or when it has none, and one more when the walk runs past
// the longest length. The length walk in the datapath steps one code length per
// cycle and the lookup waits on the registered read of the entry memory.
// One item is in work at a time; a new item is taken while a finished result still
// sits in the output register, but the next result waits until the receiver has
// taken that one, so an output stall holds the next item in work.
// The presence bits are flops cleared at reset, so no clearing pass is needed.
// Depends on chtb_pkg, chtb_if, chtb_ctrl and chtb_dp.
module canonical_huffman_table_builder import chtb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    chtb_in_if.sink     i_in,
    chtb_out_if.source  o_out
);

    t_cmd    w_cmd;
    t_stat   w_stat;
    t_result w_result;

    chtb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    chtb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_in.req_type),
        .i_first_byte (i_in.first_byte),
        .i_data_byte  (i_in.data_byte),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_result     (w_result)
    );

    // Result fields onto the output channel
    assign o_out.answer_kind   = w_result.answer_kind;
    assign o_out.symbol_value  = w_result.symbol_value;
    assign o_out.code_size     = w_result.code_size;
    assign o_out.code_bits     = w_result.code_bits;
    assign o_out.found         = w_result.found;
    assign o_out.code_overflow = w_result.code_overflow;
    assign o_out.spec_done     = w_result.spec_done;

endmodule

// ===== sv/chtb_checker.sv =====
// Port-level checks for the canonical Huffman table builder, and their bind.
// Depends on chtb_pkg and the top level canonical_huffman_table_builder.
module chtb_checker import chtb_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_req_type,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic              i_out_kind,
    input logic [SYM_W-1:0]  i_out_sym,
    input logic [LEN_W-1:0]  i_out_len,
    input logic [CODE_W-1:0] i_out_code,
    input logic              i_out_found,
    input logic              i_out_ovf,
    input logic              i_out_done
);

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_sym) && $stable(i_out_len) && $stable(i_out_code)
            && $stable(i_out_found) && $stable(i_out_ovf) && $stable(i_out_done))
        else $error("output transaction changed while stalled");

    // Lookup answers never carry spec flags
    a_lookup_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_LOOKUP) |-> !i_out_done && !i_out_ovf)
        else $error("lookup answer with spec flags");

    // A miss reports zero length and code
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_LOOKUP) && !i_out_found
            |-> (i_out_len == '0) && (i_out_code == '0))
        else $error("lookup miss with nonzero code");

    // Assignments use a real code length
    a_assign_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_ASSIGN)
            |-> (i_out_len != '0) && (i_out_len <= LEN_W'(MAX_CODE_LENGTH)))
        else $error("assignment with bad code length");

    // A lookup occupies the block for its table read
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_req_type == REQ_LOOKUP) |=> !i_in_ready)
        else $error("input taken during lookup read");

endmodule

bind canonical_huffman_table_builder chtb_checker u_chtb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_in_req_type (i_in.req_type),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.answer_kind),
    .i_out_sym     (o_out.symbol_value),
    .i_out_len     (o_out.code_size),
    .i_out_code    (o_out.code_bits),
    .i_out_found   (o_out.found),
    .i_out_ovf     (o_out.code_overflow),
    .i_out_done    (o_out.spec_done)
);
